[design/assert_macros.svh]
// Assertion macros for the checker file of the age-ordered FIFO unit.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

[design/tcaf_pkg.sv]
// Shared types and constants of the two-class age-ordered FIFO unit.
// No dependencies.
package tcaf_pkg;

    localparam int DEPTH_DEFAULT    = 16;
    localparam int TAG_BITS_DEFAULT = 16;
    localparam int TAG_W            = 16;
    localparam int STAMP_W          = 16;

    typedef enum logic [1:0] {
        ACT_ENQUEUE   = 2'd0,
        ACT_TAKE_ANY  = 2'd1,
        ACT_TAKE_KIND = 2'd2
    } tcaf_action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } tcaf_status_t;

    typedef struct packed {
        logic [1:0]       action;
        logic             kind;
        logic [TAG_W-1:0] item_tag;
    } tcaf_in_t;

    typedef struct packed {
        tcaf_status_t       status;
        logic               out_kind;
        logic [TAG_W-1:0]   out_tag;
        logic [STAMP_W-1:0] out_stamp;
    } tcaf_out_t;

    typedef struct packed {
        logic empty;
        logic full;
    } tcaf_fifo_stat_t;

endpackage

[design/tcaf_class_fifo.sv]
// One circular class FIFO with a registered head read port.
// Depends on tcaf_pkg for the status struct.
module tcaf_class_fifo #(
    parameter int DEPTH   = 16,
    parameter int TAG_W   = 16,
    parameter int STAMP_W = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic                     pop,
    input  logic [TAG_W-1:0]         push_tag,
    input  logic [STAMP_W-1:0]       push_stamp,
    output logic [TAG_W-1:0]         head_tag,
    output logic [STAMP_W-1:0]       head_stamp,
    output tcaf_pkg::tcaf_fifo_stat_t stat
);
    import tcaf_pkg::*;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = TAG_W + STAMP_W;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] head_entry_reg;
    logic [ENTRY_W-1:0] push_entry;
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   head_next;
    logic [PTR_W-1:0]   tail_reg;
    logic [PTR_W-1:0]   tail_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign push_entry = {push_tag, push_stamp};
    assign head_next  = pop ? advance(head_reg) : head_reg;
    assign tail_next  = push ? advance(tail_reg) : tail_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // The read port always fetches the entry that will be at the head next cycle.
    // A write to that same entry is forwarded so a push into an empty queue is seen.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= push_entry;
        end
        if (push && (tail_reg == head_next))
        begin
            head_entry_reg <= push_entry;
        end
        else
        begin
            head_entry_reg <= mem[head_next];
        end
    end

    assign head_tag   = head_entry_reg[ENTRY_W-1:STAMP_W];
    assign head_stamp = head_entry_reg[STAMP_W-1:0];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));

endmodule

[design/two_class_age_ordered_fifo_unit.sv]
// Top level of the two-class age-ordered FIFO unit.
// Depends on tcaf_pkg and tcaf_class_fifo.

// Each accepted item is served in the cycle it is accepted, and its single result
// item appears in the output register on the next cycle, so the unit sustains one
// item per clock; in_ready drops only while a result waits and out_ready is low.
// Each class queue holds DEPTH items in a memory whose registered read port always
// holds the current head, so enqueue, take-any and take-of-class are all served in the
// cycle they are accepted. No clearing pass is needed after reset. Stamps are 16 bits
// and wrap, and take-any decides age by the sign of the modular difference of the head
// stamps, preferring the second class on a tie.
module two_class_age_ordered_fifo_unit #(
    parameter int DEPTH    = tcaf_pkg::DEPTH_DEFAULT,
    parameter int TAG_BITS = tcaf_pkg::TAG_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tcaf_pkg::tcaf_in_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output tcaf_pkg::tcaf_out_t out_data
);
    import tcaf_pkg::*;

    localparam int STORE_TAG_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    logic                   in_accept;
    logic                   push_first_req;
    logic                   push_second_req;
    logic                   pop_first_req;
    logic                   pop_second_req;
    logic                   sel_second;
    logic [STAMP_W-1:0]     stamp_diff;
    logic [STORE_TAG_W-1:0] first_tag;
    logic [STORE_TAG_W-1:0] second_tag;
    logic [STORE_TAG_W-1:0] push_tag;
    logic [STAMP_W-1:0]     first_stamp;
    logic [STAMP_W-1:0]     second_stamp;
    tcaf_fifo_stat_t        first_stat;
    tcaf_fifo_stat_t        second_stat;
    logic [STAMP_W-1:0]     next_stamp_reg;
    logic [STAMP_W-1:0]     next_stamp_next;
    tcaf_out_t              result;
    tcaf_out_t              out_data_reg;
    logic                   out_valid_reg;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign push_tag  = in_data.item_tag[STORE_TAG_W-1:0];

    tcaf_class_fifo #(
        .DEPTH   (DEPTH),
        .TAG_W   (STORE_TAG_W),
        .STAMP_W (STAMP_W)
    ) u_first_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_accept && push_first_req),
        .pop        (in_accept && pop_first_req),
        .push_tag   (push_tag),
        .push_stamp (next_stamp_reg),
        .head_tag   (first_tag),
        .head_stamp (first_stamp),
        .stat       (first_stat)
    );

    tcaf_class_fifo #(
        .DEPTH   (DEPTH),
        .TAG_W   (STORE_TAG_W),
        .STAMP_W (STAMP_W)
    ) u_second_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_accept && push_second_req),
        .pop        (in_accept && pop_second_req),
        .push_tag   (push_tag),
        .push_stamp (next_stamp_reg),
        .head_tag   (second_tag),
        .head_stamp (second_stamp),
        .stat       (second_stat)
    );

    // The first class is older when its head stamp lies behind the second's.
    assign stamp_diff = first_stamp - second_stamp;
    assign sel_second = first_stat.empty || (!second_stat.empty && !stamp_diff[STAMP_W-1]);

    always_comb
    begin
        result          = '0;
        result.status   = ST_DONE;
        push_first_req  = 1'b0;
        push_second_req = 1'b0;
        pop_first_req   = 1'b0;
        pop_second_req  = 1'b0;
        next_stamp_next = next_stamp_reg;
        case (in_data.action)
            ACT_ENQUEUE:
            begin
                result.out_kind = in_data.kind;
                if (in_data.kind ? second_stat.full : first_stat.full)
                begin
                    result.status = ST_FULL;
                end
                else
                begin
                    push_first_req   = !in_data.kind;
                    push_second_req  = in_data.kind;
                    result.out_stamp = next_stamp_reg;
                    next_stamp_next  = next_stamp_reg + 1'b1;
                end
            end
            ACT_TAKE_ANY:
            begin
                if (first_stat.empty && second_stat.empty)
                begin
                    result.status = ST_EMPTY;
                end
                else if (sel_second)
                begin
                    pop_second_req   = 1'b1;
                    result.out_kind  = 1'b1;
                    result.out_tag   = TAG_W'(second_tag);
                    result.out_stamp = second_stamp;
                end
                else
                begin
                    pop_first_req    = 1'b1;
                    result.out_tag   = TAG_W'(first_tag);
                    result.out_stamp = first_stamp;
                end
            end
            ACT_TAKE_KIND:
            begin
                result.out_kind = in_data.kind;
                if (in_data.kind ? second_stat.empty : first_stat.empty)
                begin
                    result.status = ST_EMPTY;
                end
                else if (in_data.kind)
                begin
                    pop_second_req   = 1'b1;
                    result.out_tag   = TAG_W'(second_tag);
                    result.out_stamp = second_stamp;
                end
                else
                begin
                    pop_first_req    = 1'b1;
                    result.out_tag   = TAG_W'(first_tag);
                    result.out_stamp = first_stamp;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_stamp_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                next_stamp_reg <= next_stamp_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[design/tcaf_checker.sv]
// Port-level checker for the two-class age-ordered FIFO unit, bound to the top level.
// Depends on tcaf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcaf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input tcaf_pkg::tcaf_out_t out_data
);
    import tcaf_pkg::*;

    logic fail_result;
    logic out_stall;

    assign fail_result = out_valid && (out_data.status != ST_DONE);
    assign out_stall   = out_valid && !out_ready;

    // Every accepted item has its result ready on the following cycle.
    `ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid)

    // With no result pending the unit always takes an item.
    `ASSERT_IMPLIES(a_ready_when_idle, clk, rst_n, !out_valid, in_ready)

    // A stalled result holds its payload.
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, out_stall, out_valid && $stable(out_data))

    // Only a successful removal carries a tag; the check covers failed requests.
    `ASSERT_IMPLIES(a_tag_only_on_done, clk, rst_n, fail_result, out_data.out_tag == '0)

    // Failed requests report no stamp.
    `ASSERT_IMPLIES(a_no_stamp_on_fail, clk, rst_n, fail_result, out_data.out_stamp == '0)

endmodule

bind two_class_age_ordered_fifo_unit tcaf_checker u_tcaf_checker (.*);

[test/tb_top.sv]
// Self-checking testbench for the two-class age-ordered FIFO unit.
// Depends on tcaf_pkg and two_class_age_ordered_fifo_unit; it predicts every result
// item and compares it with what the unit returns.
`timescale 1ns / 1ps

module tb_top;
    import tcaf_pkg::*;

    localparam int           QUEUE_DEPTH   = DEPTH_DEFAULT;
    localparam logic [1:0]   ACT_UNUSED    = 2'd3;
    localparam int           IDLE_PERCENT  = 19;
    localparam int           RANDOM_ITEMS  = 1650;
    localparam int           BURST_ITEMS   = 100;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } shelf_slot_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    tcaf_in_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    tcaf_out_t out_data;

    shelf_slot_t        first_class_q[$];
    shelf_slot_t        second_class_q[$];
    logic [STAMP_W-1:0] stamp_next = '0;
    tcaf_out_t          shelter_replies[$];

    bit no_idle = 1'b0;
    int stall_request = 0;
    int stall_left = 0;
    int mismatch_count = 0;
    int request_count = 0;
    int result_count = 0;
    int full_count = 0;
    int empty_count = 0;

    two_class_age_ordered_fifo_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #6 clk = ~clk;

    function automatic tcaf_out_t take_head(input logic knd);
        tcaf_out_t   res;
        shelf_slot_t slot;
        res = '0;
        if (knd)
            slot = second_class_q.pop_front();
        else
            slot = first_class_q.pop_front();
        res.status    = ST_DONE;
        res.out_kind  = knd;
        res.out_tag   = slot.tag;
        res.out_stamp = slot.stamp;
        return res;
    endfunction

    function automatic tcaf_out_t shelter_reply_for(input tcaf_in_t req);
        tcaf_out_t          res;
        shelf_slot_t        slot;
        logic [STAMP_W-1:0] age_diff;
        int                 fill;
        res = '0;
        case (req.action)
            ACT_ENQUEUE: begin
                res.out_kind = req.kind;
                fill = req.kind ? second_class_q.size() : first_class_q.size();
                if (fill >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    slot.tag   = req.item_tag;
                    slot.stamp = stamp_next;
                    if (req.kind)
                        second_class_q.push_back(slot);
                    else
                        first_class_q.push_back(slot);
                    res.out_stamp = stamp_next;
                    stamp_next = stamp_next + 1'b1;
                end
            end
            ACT_TAKE_ANY: begin
                if (first_class_q.size() == 0 && second_class_q.size() == 0) begin
                    res.status = ST_EMPTY;
                end else if (first_class_q.size() == 0) begin
                    res = take_head(1'b1);
                end else if (second_class_q.size() == 0) begin
                    res = take_head(1'b0);
                end else begin
                    age_diff = first_class_q[0].stamp - second_class_q[0].stamp;
                    res = take_head(age_diff[STAMP_W-1] ? 1'b0 : 1'b1);
                end
            end
            ACT_TAKE_KIND: begin
                fill = req.kind ? second_class_q.size() : first_class_q.size();
                if (fill == 0) begin
                    res.status   = ST_EMPTY;
                    res.out_kind = req.kind;
                end else begin
                    res = take_head(req.kind);
                end
            end
            default: res = '0;
        endcase
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is accepted.
    task automatic send_item(input logic [1:0] act, input logic knd,
                             input logic [TAG_W-1:0] tag);
        tcaf_in_t req;
        req.action   = act;
        req.kind     = knd;
        req.item_tag = tag;
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        shelter_replies.push_back(shelter_reply_for(req));
        request_count++;
        @(negedge clk);
    endtask

    task automatic send_random_request(input int enqueue_weight);
        int pick;
        pick = $urandom_range(99);
        if (pick < enqueue_weight)
            send_item(ACT_ENQUEUE, 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
        else if (pick[0])
            send_item(ACT_TAKE_ANY, 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
        else
            send_item(ACT_TAKE_KIND, 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
    endtask

    task automatic wait_for_replies(input int limit);
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (shelter_replies.size() != 0 && waited < limit) begin
            @(negedge clk);
            waited++;
        end
    endtask

    task automatic test_empty_requests();
        send_item(ACT_TAKE_ANY, 1'b0, 16'h0000);
        send_item(ACT_TAKE_KIND, 1'b0, 16'hFFFF);
        send_item(ACT_TAKE_KIND, 1'b1, 16'h0000);
        send_item(ACT_UNUSED, 1'b1, 16'hFFFF);
    endtask

    task automatic test_fill_and_age();
        logic [TAG_W-1:0] tag;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            tag = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom_range(16'hFFFF));
            send_item(ACT_ENQUEUE, 1'b0, tag);
        end
        send_item(ACT_ENQUEUE, 1'b0, 16'hA5A5);
        send_item(ACT_ENQUEUE, 1'b1, 16'h5A5A);
        send_item(ACT_TAKE_ANY, 1'b1, 16'h0000);
        send_item(ACT_TAKE_KIND, 1'b1, 16'h0000);
        send_item(ACT_TAKE_ANY, 1'b0, 16'h0000);
    endtask

    task automatic test_mixed_traffic();
        int sent;
        int weight;
        sent   = 0;
        weight = 50;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 120 == 0) begin
                case ($urandom_range(2))
                    0: weight = 15;
                    1: weight = 50;
                    default: weight = 85;
                endcase
            end
            if ($urandom_range(99) < 3) begin
                send_item(ACT_UNUSED, 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
            end else begin
                send_random_request(weight);
                sent++;
            end
        end
    endtask

    task automatic test_output_stall();
        stall_request = 150;
        for (int i = 0; i < 40; i++)
            send_random_request(60);
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 20; i++)
            send_random_request(50);
        wait_for_replies(5000);
        for (int i = 0; i < 20; i++)
            send_random_request(50);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        for (int i = 0; i < BURST_ITEMS; i++)
            send_random_request(50);
        no_idle = 1'b0;
    endtask

    always @(negedge clk) begin
        if (stall_request > 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (no_idle) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin
        tcaf_out_t want;
        if (rst_n && out_valid && out_ready) begin
            if (shelter_replies.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result item, expected none, actual %h",
                         $time, out_data);
            end else begin
                want = shelter_replies.pop_front();
                result_count++;
                if (want.status == ST_FULL)
                    full_count++;
                if (want.status == ST_EMPTY)
                    empty_count++;
                check_field("status", 32'(want.status), 32'(out_data.status));
                check_field("out_kind", 32'(want.out_kind), 32'(out_data.out_kind));
                check_field("out_tag", 32'(want.out_tag), 32'(out_data.out_tag));
                check_field("out_stamp", 32'(want.out_stamp), 32'(out_data.out_stamp));
            end
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_requests();
        test_fill_and_age();
        test_mixed_traffic();
        test_output_stall();
        test_drain_pause();
        test_back_to_back();
        wait_for_replies(2000);
        repeat (10) @(negedge clk);
        if (shelter_replies.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d expected result items never arrived",
                     $time, shelter_replies.size());
        end
        $display("Sent %0d requests and checked %0d results, %0d of them full and %0d empty.",
                 request_count, result_count, full_count, empty_count);
        $display("Traffic mixed random idling, a long output stall, a drain and a burst; %0d %s",
                 mismatch_count, "mismatches were seen.");
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("Run timed out after %0d requests.", request_count);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
